// File: hw/rtl/branch_direction_predictor_unit_defines.svh
// Assertion macros shared by the branch direction predictor RTL.
// Used by bdp_ctrl and bdp_datapath; expects clk and rst_n in scope.
`ifndef BRANCH_DIRECTION_PREDICTOR_UNIT_DEFINES_SVH
`define BRANCH_DIRECTION_PREDICTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bdp assertion failed");
`define BDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bdp assertion failed");
`else
`define BDP_ASSERT_IMP(lbl, ante, cons)
`define BDP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/bdp_pkg.sv
// Package for the branch direction predictor: codes, widths, command and status types.
// No dependencies; used by bdp_ctrl, bdp_datapath and the top level.
`default_nettype none
package bdp_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned WORD_W   = ADDR_W - 2;
    localparam int unsigned RECIP_W  = WORD_W + 1;
    localparam int unsigned CTR_W    = 2;
    localparam int unsigned SCHEME_W = 2;

    localparam logic [SCHEME_W-1:0] SCHEME_TAKEN     = 2'd0;
    localparam logic [SCHEME_W-1:0] SCHEME_NOT_TAKEN = 2'd1;
    localparam logic [SCHEME_W-1:0] SCHEME_BIMODAL   = 2'd2;
    localparam logic [SCHEME_W-1:0] SCHEME_LOCAL     = 2'd3;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    localparam logic [CTR_W-1:0] CTR_MIN = 2'd0;
    localparam logic [CTR_W-1:0] CTR_MAX = 2'd3;
    localparam logic [CTR_W-1:0] CTR_ONE = 2'd1;

    typedef struct packed {
        logic clear;
        logic load;
        logic mul;
        logic scale;
        logic reduce;
        logic read;
        logic read_pat;
        logic eval;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

    function automatic logic [CTR_W-1:0] ctr_move(input logic [CTR_W-1:0] ctr,
                                                  input logic taken);
        logic [CTR_W-1:0] res;
        if (taken)
        begin
            res = (ctr == CTR_MAX) ? CTR_MAX : ctr + CTR_ONE;
        end
        else
        begin
            res = (ctr == CTR_MIN) ? CTR_MIN : ctr - CTR_ONE;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bdp_ctrl.sv
// Sequencer for the branch direction predictor: table clear after reset and request steps.
// Depends on bdp_pkg and the assertion macro header.
`default_nettype none
`include "branch_direction_predictor_unit_defines.svh"
module bdp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire bdp_pkg::dp_status_t status,
    output bdp_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_REDUCE,
        ST_READ,
        ST_PATTERN,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
                state_next = ST_PATTERN;
            end
            ST_PATTERN:
            begin
                cmd.read_pat = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `BDP_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd))
    `BDP_ASSERT_NEXT(a_load_to_mul, cmd.load, state_reg == ST_MUL)
    `BDP_ASSERT_NEXT(a_eval_to_idle, cmd.eval, state_reg == ST_IDLE && !busy)
    `BDP_ASSERT_NEXT(a_clear_once, state_reg != ST_CLEAR, state_reg != ST_CLEAR)

endmodule
`default_nettype wire

// File: hw/rtl/bdp_datapath.sv
// Datapath of the branch direction predictor: index reduction, counter and history tables.
// Depends on bdp_pkg and the assertion macro header.
`default_nettype none
`include "branch_direction_predictor_unit_defines.svh"
module bdp_datapath #(
    parameter int unsigned ENTRIES      = 256,
    parameter int unsigned HISTORY_BITS = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire bdp_pkg::ctrl_cmd_t             cmd,
    output bdp_pkg::dp_status_t                 status,
    input  wire logic                           cfg_we,
    input  wire logic [bdp_pkg::SCHEME_W-1:0]   cfg_wdata,
    input  wire logic                           operation,
    input  wire logic [bdp_pkg::ADDR_W-1:0]     branch_address,
    input  wire logic                           was_correct,
    output logic                                predict_taken,
    output logic                                done
);

    localparam int unsigned IDX_W     = $clog2(ENTRIES);
    localparam int unsigned CLR_W     = IDX_W + HISTORY_BITS;
    localparam int unsigned PAT_DEPTH = ENTRIES << HISTORY_BITS;
    localparam int unsigned RED_SHIFT = bdp_pkg::WORD_W + IDX_W;
    localparam int unsigned PROD_W    = bdp_pkg::WORD_W + bdp_pkg::RECIP_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RED_SHIFT) / 64'(ENTRIES);
    localparam logic [bdp_pkg::RECIP_W-1:0] RECIP = RECIP_FULL[bdp_pkg::RECIP_W-1:0];
    localparam logic [bdp_pkg::WORD_W-1:0]  ENT_C = bdp_pkg::WORD_W'(ENTRIES);
    localparam logic [CLR_W-1:0]            CLR_LAST = CLR_W'(PAT_DEPTH - 1);

    logic [bdp_pkg::CTR_W-1:0] bim_mem [ENTRIES];
    logic [HISTORY_BITS-1:0]   hist_mem [ENTRIES];
    logic [bdp_pkg::CTR_W-1:0] pat_mem [PAT_DEPTH];

    logic [bdp_pkg::SCHEME_W-1:0] scheme_reg;
    logic [CLR_W-1:0]             clr_reg;
    logic                         op_reg;
    logic                         correct_reg;
    logic [bdp_pkg::WORD_W-1:0]   x_reg;
    logic [PROD_W-1:0]            prod_reg;
    logic [bdp_pkg::WORD_W-1:0]   qmul_reg;
    logic [IDX_W-1:0]             entry_reg;
    logic [bdp_pkg::CTR_W-1:0]    bim_rd_reg;
    logic [HISTORY_BITS-1:0]      hist_rd_reg;
    logic [bdp_pkg::CTR_W-1:0]    pat_rd_reg;
    logic                         done_reg;
    logic                         taken_reg;

    logic [PROD_W-1:0]            prod_shift;
    logic [bdp_pkg::WORD_W-1:0]   q_est;
    logic [2*bdp_pkg::WORD_W-1:0] qmul_full;
    logic [bdp_pkg::WORD_W-1:0]   rem;
    logic [bdp_pkg::WORD_W-1:0]   rem_adj;
    logic [IDX_W-1:0]             clr_entry;
    logic [CLR_W-1:0]             pat_idx;
    logic [bdp_pkg::CTR_W-1:0]    ctr;
    logic                         outcome;
    logic [bdp_pkg::CTR_W-1:0]    ctr_new;
    logic [HISTORY_BITS:0]        hist_shift;
    logic                         wr_bim;
    logic                         wr_local;
    logic                         taken_next;

    assign prod_shift = prod_reg >> RED_SHIFT;
    assign q_est      = prod_shift[bdp_pkg::WORD_W-1:0];
    assign qmul_full  = q_est * ENT_C;
    assign rem        = x_reg - qmul_reg;
    assign rem_adj    = (rem >= ENT_C) ? rem - ENT_C : rem;
    assign clr_entry  = clr_reg[CLR_W-1:HISTORY_BITS];
    assign pat_idx    = {entry_reg, hist_rd_reg};
    assign ctr        = (scheme_reg == bdp_pkg::SCHEME_LOCAL) ? pat_rd_reg : bim_rd_reg;
    assign outcome    = ctr[1] ^ ~correct_reg;
    assign ctr_new    = bdp_pkg::ctr_move(ctr, outcome);
    assign hist_shift = {hist_rd_reg, outcome};
    assign wr_bim     = cmd.eval && (op_reg == bdp_pkg::OP_UPDATE)
                        && (scheme_reg == bdp_pkg::SCHEME_BIMODAL);
    assign wr_local   = cmd.eval && (op_reg == bdp_pkg::OP_UPDATE)
                        && (scheme_reg == bdp_pkg::SCHEME_LOCAL);
    assign status.clear_last = (clr_reg == CLR_LAST);

    always_comb
    begin
        case (scheme_reg)
            bdp_pkg::SCHEME_TAKEN:     taken_next = 1'b1;
            bdp_pkg::SCHEME_NOT_TAKEN: taken_next = 1'b0;
            default:                   taken_next = ctr[1];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg <= bdp_pkg::SCHEME_TAKEN;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                scheme_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                clr_reg <= clr_reg + CLR_W'(1);
            end
            done_reg <= cmd.eval && (op_reg == bdp_pkg::OP_PREDICT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= operation;
            correct_reg <= was_correct;
            x_reg       <= branch_address[bdp_pkg::ADDR_W-1:2];
        end
        if (cmd.mul)
        begin
            prod_reg <= x_reg * RECIP;
        end
        if (cmd.scale)
        begin
            qmul_reg <= qmul_full[bdp_pkg::WORD_W-1:0];
        end
        if (cmd.reduce)
        begin
            entry_reg <= rem_adj[IDX_W-1:0];
        end
        if (cmd.eval)
        begin
            taken_reg <= taken_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            bim_mem[clr_entry] <= '0;
        end
        else if (wr_bim)
        begin
            bim_mem[entry_reg] <= ctr_new;
        end
        if (cmd.read)
        begin
            bim_rd_reg <= bim_mem[entry_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            hist_mem[clr_entry] <= '0;
        end
        else if (wr_local)
        begin
            hist_mem[entry_reg] <= hist_shift[HISTORY_BITS-1:0];
        end
        if (cmd.read)
        begin
            hist_rd_reg <= hist_mem[entry_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            pat_mem[clr_reg] <= '0;
        end
        else if (wr_local)
        begin
            pat_mem[pat_idx] <= ctr_new;
        end
        if (cmd.read_pat)
        begin
            pat_rd_reg <= pat_mem[pat_idx];
        end
    end

    assign predict_taken = taken_reg;
    assign done          = done_reg;

    `BDP_ASSERT_NEXT(a_done_after_predict, cmd.eval && op_reg == bdp_pkg::OP_PREDICT, done_reg)
    `BDP_ASSERT_IMP(a_done_source, done_reg, $past(cmd.eval))
    `BDP_ASSERT_IMP(a_rem_bound, cmd.reduce, rem < (ENT_C << 1))
    `BDP_ASSERT_IMP(a_no_write_in_clear, cmd.clear, !wr_bim && !wr_local)

endmodule
`default_nettype wire

// File: hw/rtl/branch_direction_predictor_unit.sv
// Top level of the branch direction predictor: sequencer plus datapath.
// Depends on bdp_pkg, bdp_ctrl and bdp_datapath.
//
//   Channel   Handshake               Payload
//   request   start, busy             operation, branch_address, was_correct
//   result    done (one-cycle strobe) predict_taken
//   config    cfg_we                  cfg_wdata (scheme)
//
// A request is taken when start is high and busy is low; busy then stays high through the
// index multiply, scale, reduce, table read, pattern read and evaluate steps, and no new
// request is taken meanwhile. The predict result strobes done in the cycle after evaluation.
// After reset busy is high while the tables are cleared one pattern entry per cycle, all
// ENTRIES * 2**HISTORY_BITS of them. The receiver cannot stall; updates give no result.
`default_nettype none
module branch_direction_predictor_unit #(
    parameter int unsigned ENTRIES      = 256,
    parameter int unsigned HISTORY_BITS = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         operation,
    input  wire logic [bdp_pkg::ADDR_W-1:0]   branch_address,
    input  wire logic                         was_correct,
    output logic                              done,
    output logic                              predict_taken,
    input  wire logic                         cfg_we,
    input  wire logic [bdp_pkg::SCHEME_W-1:0] cfg_wdata
);

    bdp_pkg::ctrl_cmd_t  cmd;
    bdp_pkg::dp_status_t status;

    bdp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    bdp_datapath #(
        .ENTRIES      (ENTRIES),
        .HISTORY_BITS (HISTORY_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .operation      (operation),
        .branch_address (branch_address),
        .was_correct    (was_correct),
        .predict_taken  (predict_taken),
        .done           (done)
    );

endmodule
`default_nettype wire
